### rtl/core/pss_pkg.sv
package pss_pkg;

	// Timer width; the timeout, settle and halt delay registers are 16 bits wide.
	localparam int TIMER_BITS = 16;
	localparam int CFG_W      = 16;
	localparam int CMP_W      = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
	localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

	// Register indexes
	localparam logic [2:0] REG_DEBOUNCE     = 3'd0;
	localparam logic [2:0] REG_BOOT_TIMEOUT = 3'd1;
	localparam logic [2:0] REG_BOOT_SETTLE  = 3'd2;
	localparam logic [2:0] REG_HALT_DELAY   = 3'd3;
	localparam logic [2:0] REG_RESET_PULSE  = 3'd4;

	// Reset values of the registers
	localparam logic [7:0]  DEBOUNCE_RST     = 8'd200;
	localparam logic [15:0] BOOT_TIMEOUT_RST = 16'd2000;
	localparam logic [15:0] BOOT_SETTLE_RST  = 16'd100;
	localparam logic [15:0] HALT_DELAY_RST   = 16'd750;
	localparam logic [7:0]  RESET_PULSE_RST  = 8'd1;

	// Phase codes as seen on the port
	localparam logic [2:0] PH_SLEEP      = 3'd0;
	localparam logic [2:0] PH_ON         = 3'd1;
	localparam logic [2:0] PH_WAIT_BOOT  = 3'd2;
	localparam logic [2:0] PH_SETTLE     = 3'd3;
	localparam logic [2:0] PH_WAIT_HALT  = 3'd4;
	localparam logic [2:0] PH_HALT_DELAY = 3'd5;
	localparam logic [2:0] PH_RESET      = 3'd6;

	typedef enum logic [6:0] {
		ST_SLEEP      = 7'b0000001,
		ST_ON         = 7'b0000010,
		ST_WAIT_BOOT  = 7'b0000100,
		ST_SETTLE     = 7'b0001000,
		ST_WAIT_HALT  = 7'b0010000,
		ST_HALT_DELAY = 7'b0100000,
		ST_RESET      = 7'b1000000
	} state_t;

	typedef struct packed {
		logic [7:0]  debounce_ticks;
		logic [15:0] boot_timeout_ticks;
		logic [15:0] boot_settle_ticks;
		logic [15:0] halt_delay_ticks;
		logic [7:0]  reset_pulse_ticks;
	} cfg_t;

	typedef struct packed {
		logic       supply_enable;
		logic       peripheral_enable;
		logic       host_reset;
		logic [2:0] phase;
	} res_t;

	function automatic logic [2:0] phase_code(state_t st);
		logic [2:0] code;
		case (st)
			ST_ON:         code = PH_ON;
			ST_WAIT_BOOT:  code = PH_WAIT_BOOT;
			ST_SETTLE:     code = PH_SETTLE;
			ST_WAIT_HALT:  code = PH_WAIT_HALT;
			ST_HALT_DELAY: code = PH_HALT_DELAY;
			ST_RESET:      code = PH_RESET;
			default:       code = PH_SLEEP;
		endcase
		return code;
	endfunction

endpackage

### rtl/core/pss_cfg.sv
module pss_cfg import pss_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic [2:0]  wr_index,
	input  logic [15:0] wr_data,
	output cfg_t        cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ticks     <= DEBOUNCE_RST;
			cfg_q.boot_timeout_ticks <= BOOT_TIMEOUT_RST;
			cfg_q.boot_settle_ticks  <= BOOT_SETTLE_RST;
			cfg_q.halt_delay_ticks   <= HALT_DELAY_RST;
			cfg_q.reset_pulse_ticks  <= RESET_PULSE_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_DEBOUNCE:     cfg_q.debounce_ticks     <= wr_data[7:0];
				REG_BOOT_TIMEOUT: cfg_q.boot_timeout_ticks <= wr_data;
				REG_BOOT_SETTLE:  cfg_q.boot_settle_ticks  <= wr_data;
				REG_HALT_DELAY:   cfg_q.halt_delay_ticks   <= wr_data;
				REG_RESET_PULSE:  cfg_q.reset_pulse_ticks  <= wr_data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### rtl/core/pss_step.sv
module pss_step import pss_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic tick,
	input  logic switch_on,
	input  logic host_running,
	input  cfg_t cfg,
	output res_t res
);

	state_t                state_q, state_d;
	logic [7:0]            deb_q, deb_d;
	logic [TIMER_BITS-1:0] timer_q, timer_d, timer_inc;
	logic [7:0]            deb_inc;
	logic                  settle_done, halt_done, pulse_done, boot_done;

	assign timer_inc = (timer_q == TIMER_MAX) ? timer_q : timer_q + 1'b1;
	assign deb_inc   = (deb_q < cfg.debounce_ticks) ? deb_q + 8'd1 : deb_q;

	// holds count the entry tick, so compare against the incremented timer
	assign boot_done   = host_running ||
		(CMP_W'(timer_inc) >= CMP_W'(cfg.boot_timeout_ticks));
	assign settle_done = CMP_W'(timer_inc) >= CMP_W'(cfg.boot_settle_ticks);
	assign halt_done   = CMP_W'(timer_inc) >= CMP_W'(cfg.halt_delay_ticks);
	assign pulse_done  = CMP_W'(timer_inc) >= CMP_W'(cfg.reset_pulse_ticks);

	always_comb begin
		state_d = state_q;
		deb_d   = deb_q;
		timer_d = timer_q;
		case (state_q)
			ST_ON: begin
				if (switch_on) begin
					deb_d = '0;
				end else begin
					deb_d = deb_inc;
					if (deb_inc >= cfg.debounce_ticks) begin
						timer_d = '0;
						state_d = host_running ? ST_WAIT_HALT : ST_WAIT_BOOT;
					end
				end
			end
			ST_WAIT_BOOT: begin
				timer_d = timer_inc;
				if (boot_done) begin
					timer_d = '0;
					state_d = ST_SETTLE;
				end
			end
			ST_SETTLE: begin
				timer_d = timer_inc;
				if (settle_done) begin
					timer_d = '0;
					if (switch_on) begin
						deb_d   = '0;
						state_d = ST_ON;
					end else begin
						state_d = ST_WAIT_HALT;
					end
				end
			end
			ST_WAIT_HALT: begin
				if (!host_running) begin
					timer_d = '0;
					state_d = ST_HALT_DELAY;
				end
			end
			ST_HALT_DELAY: begin
				timer_d = timer_inc;
				if (halt_done) begin
					timer_d = '0;
					state_d = switch_on ? ST_RESET : ST_SLEEP;
				end
			end
			ST_RESET: begin
				timer_d = timer_inc;
				if (pulse_done) begin
					timer_d = '0;
					deb_d   = '0;
					state_d = ST_ON;
				end
			end
			default: begin
				state_d = ST_SLEEP;
				if (switch_on) begin
					deb_d   = '0;
					timer_d = '0;
					state_d = ST_ON;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SLEEP;
			deb_q   <= '0;
			timer_q <= '0;
		end else if (tick) begin
			state_q <= state_d;
			deb_q   <= deb_d;
			timer_q <= timer_d;
		end
	end

	// result reflects the phase after this tick
	always_comb begin
		res.phase      = phase_code(state_d);
		res.host_reset = 1'b0;
		case (state_d)
			ST_SLEEP: begin
				res.supply_enable     = 1'b0;
				res.peripheral_enable = 1'b0;
			end
			ST_ON: begin
				res.supply_enable     = 1'b1;
				res.peripheral_enable = 1'b1;
			end
			ST_RESET: begin
				res.supply_enable     = 1'b1;
				res.peripheral_enable = 1'b1;
				res.host_reset        = 1'b1;
			end
			default: begin
				res.supply_enable     = 1'b1;
				res.peripheral_enable = switch_on;
			end
		endcase
	end

endmodule

### rtl/core/pss_outbuf.sv
module pss_outbuf import pss_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  res_t push_data,
	output logic full,
	output logic out_valid,
	input  logic out_stall,
	output res_t out_data
);

	logic out_valid_q, skid_valid_q;
	res_t out_q, skid_q;
	logic pop, load_out;

	assign pop      = out_valid_q && !out_stall;
	assign load_out = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (skid_valid_q) begin
				// no push while the skid stage is occupied
				if (pop) begin
					skid_valid_q <= 1'b0;
				end
			end else if (push) begin
				if (load_out) begin
					out_valid_q <= 1'b1;
				end else begin
					skid_valid_q <= 1'b1;
				end
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q && pop) begin
			out_q <= skid_q;
		end else if (push && load_out && !skid_valid_q) begin
			out_q <= push_data;
		end
		if (push && !load_out && !skid_valid_q) begin
			skid_q <= push_data;
		end
	end

	assign full      = skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

### rtl/core/power_switch_shutdown_sequencer_core.sv
// Power switch shutdown sequencer. Each accepted transaction is one timing tick
// with the sampled switch and host-running levels; every tick yields exactly one
// result showing supply, peripheral and host reset enables and the phase after
// that tick. The phase, debounce count and timer update in the cycle the tick is
// taken, so a tick can be taken every clock while in_stall is low; the result
// is registered in an output register with a one-entry skid stage, and in_stall
// rises only when both are occupied. Configuration writes are always ready and
// should be made while no tick is in flight; indexes above four are ignored.
module power_switch_shutdown_sequencer_core import pss_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        switch_on,
	input  logic        host_running,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        supply_enable,
	output logic        peripheral_enable,
	output logic        host_reset,
	output logic [2:0]  phase,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	cfg_t cfg;
	res_t res, out_data;
	logic tick, full;

	assign cfg_ready = 1'b1;
	assign in_stall  = full;
	assign tick      = in_valid && !full;

	pss_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	pss_step u_step (
		.clk          (clk),
		.arst_n       (arst_n),
		.tick         (tick),
		.switch_on    (switch_on),
		.host_running (host_running),
		.cfg          (cfg),
		.res          (res)
	);

	pss_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (tick),
		.push_data (res),
		.full      (full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	assign supply_enable     = out_data.supply_enable;
	assign peripheral_enable = out_data.peripheral_enable;
	assign host_reset        = out_data.host_reset;
	assign phase             = out_data.phase;

	// skid stage only fills behind a held output
	a_stall_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with no result pending");

	a_stall_clears: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall && !out_stall |=> !in_stall)
		else $error("skid stage not drained after output taken");

	a_reset_phase: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && host_reset |-> phase == PH_RESET && supply_enable)
		else $error("host reset outside reset pulse phase");

	a_sleep_supply: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !supply_enable |-> phase == PH_SLEEP && !peripheral_enable)
		else $error("supply off outside sleep phase");

endmodule
